// ===== hw/rtl/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Shared sizes, status codes, controller states and bitmap helper functions
// for the bitmap block allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

  localparam int NUM_BLOCKS = 1024;
  localparam int RESERVED   = 16;

  localparam int IDX_W    = 10;
  localparam int STATUS_W = 2;

  localparam int WORD_W    = 32;
  localparam int WORD_SH   = 5;
  localparam int MAP_WORDS = (NUM_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int RES_LIM   = (RESERVED < NUM_BLOCKS) ? RESERVED : NUM_BLOCKS;

  localparam logic [0:0] OP_ALLOC = 1'b0;
  localparam logic [0:0] OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_ALLOC   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FREED   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FREE_RD,
    S_FREE_CHK,
    S_OUT
  } state_t;

  // contents of a bitmap word right after reset
  function automatic logic [WORD_W-1:0] reset_word(input int w);
    logic [WORD_W-1:0] v;
    v = '0;
    for (int j = 0; j < WORD_W; j++) begin
      v[j] = ((w * WORD_W + j) < RES_LIM);
    end
    return v;
  endfunction

  // bits of a word that stand for real blocks
  function automatic logic [WORD_W-1:0] word_mask(input int w);
    logic [WORD_W-1:0] v;
    v = '0;
    for (int j = 0; j < WORD_W; j++) begin
      v[j] = ((w * WORD_W + j) < NUM_BLOCKS);
    end
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bba_ram.sv =====
// ----------------------------------------------------------------------------
// bba_ram
// Generic single-clock RAM, one write port and one read port, read data
// registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0]  waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0]  raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bitmap_block_allocator.sv =====
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit block allocator over a used/free bitmap held in a word-wide RAM.
// ----------------------------------------------------------------------------
// One request is worked at a time. The bitmap sits in a 32-bit wide RAM of
// MAP_WORDS words, read one word per cycle through its single read port. An
// allocate request scans from word 0 upward and takes the lowest free block,
// or reports ST_FULL when the map is full. A free request reads the word that
// holds the block and writes it back with the bit cleared if the block was in
// use; an index out of range is ignored without a read. Each word has a
// valid flop that reset clears, so a word never written reads as its reset
// contents (reserved blocks set) and no clearing pass is needed. A finished
// result waits in the output register while the next request is accepted.
`default_nettype none

module bitmap_block_allocator
  import bba_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                in_opcode,
  input  wire logic [IDX_W-1:0]    in_block_index,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic      [IDX_W-1:0]    out_result_index,
  output logic      [STATUS_W-1:0] out_status
);

  state_t state_r, state_nxt;

  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [AW:0]          scan_addr_r, scan_addr_nxt;
  logic                 chk_valid_r, chk_valid_nxt;
  logic [AW-1:0]        chk_addr_r, chk_addr_nxt;
  logic [IDX_W-1:0]     res_index_r, res_index_nxt;
  logic [STATUS_W-1:0]  res_status_r, res_status_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]     out_index_r, out_index_nxt;
  logic [STATUS_W-1:0]  out_status_r, out_status_nxt;
  logic [MAP_WORDS-1:0] row_valid_r, row_valid_nxt;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  logic [WORD_W-1:0]  cur_word;
  logic [WORD_W-1:0]  free_bits;
  logic [WORD_SH-1:0] free_pos;
  logic [AW+WORD_SH-1:0] found_blk;
  logic               idx_in_range;
  logic [AW-1:0]      idx_word;

  bba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // word never written still holds its reset contents
  assign cur_word  = row_valid_r[chk_addr_r] ? ram_rdata : reset_word(int'(chk_addr_r));
  assign free_bits = ~cur_word & word_mask(int'(chk_addr_r));

  always_comb begin
    free_pos = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (free_bits[j]) begin
        free_pos = WORD_SH'(j);
      end
    end
  end

  assign found_blk    = {chk_addr_r, free_pos};
  assign idx_in_range = (32'(idx_r) < NUM_BLOCKS);
  assign idx_word     = AW'(idx_r >> WORD_SH);

  assign in_ready         = (state_r == S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_index = out_index_r;
  assign out_status       = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    scan_addr_nxt  = scan_addr_r;
    chk_valid_nxt  = 1'b0;
    chk_addr_nxt   = chk_addr_r;
    res_index_nxt  = res_index_r;
    res_status_nxt = res_status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_index_nxt  = out_index_r;
    out_status_nxt = out_status_r;
    row_valid_nxt  = row_valid_r;
    ram_we         = 1'b0;
    ram_waddr      = chk_addr_r;
    ram_wdata      = cur_word;
    ram_re         = 1'b0;
    ram_raddr      = scan_addr_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          idx_nxt       = in_block_index;
          scan_addr_nxt = '0;
          state_nxt     = (in_opcode == OP_FREE) ? S_FREE_RD : S_SCAN;
        end
      end

      S_SCAN: begin
        if (chk_valid_r && (free_bits != '0)) begin
          ram_we                    = 1'b1;
          ram_wdata                 = cur_word | (WORD_W'(1) << free_pos);
          row_valid_nxt[chk_addr_r] = 1'b1;
          res_index_nxt             = IDX_W'(found_blk);
          res_status_nxt            = ST_ALLOC;
          state_nxt                 = S_OUT;
        end else if (chk_valid_r && (chk_addr_r == AW'(MAP_WORDS - 1))) begin
          res_index_nxt  = '0;
          res_status_nxt = ST_FULL;
          state_nxt      = S_OUT;
        end else if (scan_addr_r < (AW+1)'(MAP_WORDS)) begin
          // issue next word while the previous one is checked
          ram_re        = 1'b1;
          ram_raddr     = scan_addr_r[AW-1:0];
          chk_valid_nxt = 1'b1;
          chk_addr_nxt  = scan_addr_r[AW-1:0];
          scan_addr_nxt = scan_addr_r + 1'b1;
        end
      end

      S_FREE_RD: begin
        res_index_nxt = idx_r;
        if (idx_in_range) begin
          ram_re       = 1'b1;
          ram_raddr    = idx_word;
          chk_addr_nxt = idx_word;
          state_nxt    = S_FREE_CHK;
        end else begin
          res_status_nxt = ST_IGNORED;
          state_nxt      = S_OUT;
        end
      end

      S_FREE_CHK: begin
        if (cur_word[idx_r[WORD_SH-1:0]]) begin
          ram_we                    = 1'b1;
          ram_wdata                 = cur_word & ~(WORD_W'(1) << idx_r[WORD_SH-1:0]);
          row_valid_nxt[chk_addr_r] = 1'b1;
          res_status_nxt            = ST_FREED;
        end else begin
          res_status_nxt = ST_IGNORED;
        end
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_index_nxt  = res_index_r;
          out_status_nxt = res_status_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      chk_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      row_valid_r <= '0;
    end else begin
      state_r     <= state_nxt;
      chk_valid_r <= chk_valid_nxt;
      out_valid_r <= out_valid_nxt;
      row_valid_r <= row_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    scan_addr_r  <= scan_addr_nxt;
    chk_addr_r   <= chk_addr_nxt;
    res_index_r  <= res_index_nxt;
    res_status_r <= res_status_nxt;
    out_index_r  <= out_index_nxt;
    out_status_r <= out_status_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bba_checker.sv =====
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks for the bitmap block allocator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_checker
  import bba_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_ready,
  input wire logic                in_opcode,
  input wire logic [IDX_W-1:0]    in_block_index,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [IDX_W-1:0]    out_result_index,
  input wire logic [STATUS_W-1:0] out_status
);

  // a waiting request holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_opcode)
                              && $stable(in_block_index))
    else $error("request changed while waiting");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result_index)
                                && $stable(out_status))
    else $error("result changed while stalled");

  // one request in work at a time
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  // full reports index zero
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL) |-> (out_result_index == '0))
    else $error("full result with nonzero index");

  // no result comes out of reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind bitmap_block_allocator bba_checker u_bba_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_opcode        (in_opcode),
  .in_block_index   (in_block_index),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_result_index (out_result_index),
  .out_status       (out_status)
);

`default_nettype wire
